/* design/lfla_pkg.sv */
// Shared types and codes for the lowest-free label allocator.
package lfla_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam int LABEL_W  = 7;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    typedef struct packed {
        logic ins;
        logic rem;
        logic rd;
    } t_cmd;

endpackage

/* design/lfla_cell.sv */
// One slot of the sorted label list, with its local insert, remove and select logic.
module lfla_cell
    import lfla_pkg::*;
#(
    parameter int LW = 7,
    parameter int PW = 7,
    parameter int J  = 0
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [LW-1:0] i_count,
    input  logic [PW-1:0] i_pidx,
    input  logic          i_pre,
    output logic          o_pre,
    input  logic [LW-1:0] i_lbl_prev,
    input  logic [LW-1:0] i_lbl_next,
    output logic [LW-1:0] o_lbl,
    input  logic [LW-1:0] i_acc,
    output logic [LW-1:0] o_acc
);

    localparam logic [LW-1:0] C_OWN  = LW'(J + 1);
    localparam logic [LW-1:0] C_IDX  = LW'(J);
    localparam logic [PW-1:0] C_PIDX = PW'(J);

    logic [LW-1:0] r_lbl, n_lbl;
    logic          valid, inplace, ins_here, take_prev, take_next, sel;

    always_comb begin
        valid     = C_IDX < i_count;
        inplace   = valid && (r_lbl == C_OWN);
        o_pre     = i_pre && inplace;
        ins_here  = i_cmd.ins && i_pre && !inplace;
        take_prev = i_cmd.ins && !i_pre && (C_IDX <= i_count);
        take_next = i_cmd.rem && (C_PIDX >= i_pidx) && (C_OWN < i_count);
        sel       = (i_cmd.rem || i_cmd.rd) && (C_PIDX == i_pidx);

        priority if (ins_here) begin
            n_lbl = C_OWN;
        end else if (take_prev) begin
            n_lbl = i_lbl_prev;
        end else if (take_next) begin
            n_lbl = i_lbl_next;
        end else begin
            n_lbl = r_lbl;
        end

        o_acc = i_acc | (ins_here ? C_OWN : '0) | (sel ? r_lbl : '0);
        o_lbl = r_lbl;
    end

    always_ff @(posedge i_clk) begin
        r_lbl <= n_lbl;
    end

endmodule

/* design/lowest_free_label_allocator_unit.sv */
// Top level of the lowest-free label allocator: handshake, count and the row of slot cells.
//
// The input channel carries one request per item: insert the lowest free label, or remove
// or read the label at a 1-based position. The output channel returns one result item per
// request: the label, its 0-based slot, the count after the request and a status code.
// Every request is served by the row of cells, each of which compares
// its own label with its own slot and shifts to or from its neighbors as needed.
// The result is registered in the output register in the cycle after the request is accepted.
// One item can be accepted every cycle while the output side keeps taking results.
// When the receiver stalls, the result stays in the output register and o_stall rises,
// so no further item is accepted until the result has been taken.
// Reset empties the list and clears the output valid; slot contents are not cleared.
// Out-of-range positions, unused operation codes and inserts into a full list leave the
// list unchanged and are reported through the status field with label and slot zero.
module lowest_free_label_allocator_unit
    import lfla_pkg::*;
#(
    parameter int MAX_LABELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [LABEL_W-1:0]  o_label,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [COUNT_W-1:0]  o_count_after,
    output logic [STATUS_W-1:0] o_status
);

    localparam int LW = $clog2(MAX_LABELS + 1);
    localparam int PW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] C_MAX = LW'(MAX_LABELS);

    logic [LW-1:0]       r_count, n_count;
    logic                r_valid;
    logic [LABEL_W-1:0]  r_label;
    logic [SLOT_W-1:0]   r_slot;
    logic [COUNT_W-1:0]  r_count_after;
    t_status             r_status;

    logic                accept;
    logic                is_ins, is_rem, is_rd, pos_ok;
    logic [PW-1:0]       pos_ext, cnt_ext, pidx;
    t_cmd                cmd;
    t_status             status;
    logic [PW-1:0]       slot_full;
    logic [LW-1:0]       result_lbl;

    logic [LW-1:0]       lbl   [MAX_LABELS];
    logic [LW-1:0]       acc   [MAX_LABELS+1];
    logic                pre   [MAX_LABELS+1];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        pos_ext = PW'(i_position);
        cnt_ext = PW'(r_count);
        pidx    = pos_ext - PW'(1);
        is_ins  = (i_operation == OP_INSERT);
        is_rem  = (i_operation == OP_REMOVE);
        is_rd   = (i_operation == OP_READ);
        pos_ok  = (is_rem || is_rd) && (pos_ext != '0) && (pos_ext <= cnt_ext);

        cmd.ins = accept && is_ins && (r_count < C_MAX);
        cmd.rem = accept && is_rem && pos_ok;
        cmd.rd  = accept && is_rd && pos_ok;

        priority if (cmd.ins) begin
            n_count = r_count + LW'(1);
        end else if (cmd.rem) begin
            n_count = r_count - LW'(1);
        end else begin
            n_count = r_count;
        end

        priority if (is_ins && (r_count >= C_MAX)) begin
            status = ST_FULL;
        end else if (is_ins || pos_ok) begin
            status = ST_OK;
        end else begin
            status = ST_RANGE;
        end

        result_lbl = acc[MAX_LABELS];
        if (is_ins) begin
            slot_full = PW'(result_lbl) - PW'(1);
        end else begin
            slot_full = pidx;
        end
    end

    assign acc[0] = '0;
    assign pre[0] = 1'b1;

    for (genvar g = 0; g < MAX_LABELS; g++) begin : g_cell
        logic [LW-1:0] lbl_prev, lbl_next;

        if (g == 0) begin : g_first
            assign lbl_prev = '0;
        end else begin : g_mid
            assign lbl_prev = lbl[g-1];
        end

        if (g == MAX_LABELS - 1) begin : g_last
            assign lbl_next = '0;
        end else begin : g_inner
            assign lbl_next = lbl[g+1];
        end

        lfla_cell #(
            .LW (LW),
            .PW (PW),
            .J  (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_count    (r_count),
            .i_pidx     (pidx),
            .i_pre      (pre[g]),
            .o_pre      (pre[g+1]),
            .i_lbl_prev (lbl_prev),
            .i_lbl_next (lbl_next),
            .o_lbl      (lbl[g]),
            .i_acc      (acc[g]),
            .o_acc      (acc[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= status;
            r_count_after <= COUNT_W'(n_count);
            if (status == ST_OK) begin
                r_label <= LABEL_W'(result_lbl);
                r_slot  <= SLOT_W'(slot_full);
            end else begin
                r_label <= '0;
                r_slot  <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_label       = r_label;
    assign o_slot        = r_slot;
    assign o_count_after = r_count_after;
    assign o_status      = r_status;

endmodule

/* sim/tb_lowest_free_label_allocator_unit.sv */
// Self-checking testbench for the lowest-free label allocator with a list model and random traffic.
module tb_lowest_free_label_allocator_unit;
    import lfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH      = 64;
    localparam int          RANDOM_ITEMS    = 1640;
    localparam int          HOLD_OFF_CYCLES = 250;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          TAIL_CYCLES     = 10;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count_after;
        logic [STATUS_W-1:0] status;
    } t_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_operation;
    logic [POS_W-1:0]    i_position;
    logic                o_valid;
    logic                i_stall;
    logic [LABEL_W-1:0]  o_label;
    logic [SLOT_W-1:0]   o_slot;
    logic [COUNT_W-1:0]  o_count_after;
    logic [STATUS_W-1:0] o_status;

    logic [LABEL_W-1:0]  list_labels [LIST_DEPTH];
    int                  list_count;
    t_reply              expected_replies [$];

    int   mismatches      = 0;
    int   items_sent      = 0;
    int   replies_checked = 0;
    int   full_inserts    = 0;
    int   rejected_reads  = 0;
    int   peak_fill       = 0;
    int   sender_burst_left = 0;
    logic hold_off_req    = 1'b0;
    logic hold_active     = 1'b0;

    lowest_free_label_allocator_unit #(
        .MAX_LABELS(LIST_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_label       (o_label),
        .o_slot        (o_slot),
        .o_count_after (o_count_after),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_reply serve_request(logic [1:0] op, logic [POS_W-1:0] pos);
        t_reply reply;
        int     idx;
        int     j;
        reply        = '0;
        reply.status = ST_OK;
        if (op == OP_INSERT) begin
            if (list_count >= LIST_DEPTH) begin
                reply.status = ST_FULL;
                full_inserts++;
            end else begin
                idx = list_count;
                while (idx > 0 && int'(list_labels[idx-1]) > idx) begin
                    list_labels[idx] = list_labels[idx-1];
                    idx--;
                end
                list_labels[idx] = LABEL_W'(idx + 1);
                list_count++;
                reply.label = LABEL_W'(idx + 1);
                reply.slot  = SLOT_W'(idx);
            end
        end else if ((op != OP_REMOVE && op != OP_READ) || pos == 0 || int'(pos) > list_count) begin
            reply.status = ST_RANGE;
            rejected_reads++;
        end else begin
            idx         = int'(pos) - 1;
            reply.label = list_labels[idx];
            reply.slot  = SLOT_W'(idx);
            if (op == OP_REMOVE) begin
                for (j = idx; j + 1 < list_count; j++) begin
                    list_labels[j] = list_labels[j+1];
                end
                list_count--;
            end
        end
        reply.count_after = COUNT_W'(list_count);
        if (list_count > peak_fill) begin
            peak_fill = list_count;
        end
        return reply;
    endfunction

    function automatic int pick_sender_gap();
        int r;
        if (sender_burst_left > 0) begin
            sender_burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            sender_burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [POS_W-1:0] any_position();
        return POS_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && list_count > 0) return POS_W'($urandom_range(1, list_count));
        if (r < 80) return '0;
        if (r < 95 && list_count < 127) return POS_W'($urandom_range(list_count + 1, 127));
        return any_position();
    endfunction

    function automatic logic [1:0] pick_operation(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_UNUSED;
        if (r < 3 + insert_pct) return OP_INSERT;
        if ($urandom_range(0, 1) == 1) return OP_REMOVE;
        return OP_READ;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_position  <= pos;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_replies.push_back(serve_request(op, pos));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_request(int insert_pct);
        logic [1:0] op;
        op = pick_operation(insert_pct);
        send_request(op, (op == OP_INSERT) ? any_position() : pick_position());
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            $display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_replies.size() == 0) begin
                $display("%t: unexpected result, expected none, actual label %0d status %0d",
                         $time, o_label, o_status);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                check_field("label", want.label, o_label);
                check_field("slot", want.slot, o_slot);
                check_field("count_after", want.count_after, o_count_after);
                check_field("status", want.status, o_status);
                replies_checked++;
            end
        end
    end

    initial begin : receiver
        int   len;
        int   r;
        logic stall;
        i_stall <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                stall        = 1'b1;
                len          = HOLD_OFF_CYCLES;
            end else begin
                hold_active = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    stall = 1'b0;
                    len   = $urandom_range(30, 100);
                end else if (r < 55) begin
                    stall = 1'b0;
                    len   = $urandom_range(1, 3);
                end else if (r < 88) begin
                    stall = 1'b1;
                    len   = $urandom_range(1, 3);
                end else if (r < 97) begin
                    stall = 1'b1;
                    len   = $urandom_range(4, 12);
                end else begin
                    stall = 1'b1;
                    len   = $urandom_range(20, 50);
                end
            end
            i_stall <= stall;
            repeat (len) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic test_empty_list();
        send_request(OP_READ, 7'd1);
        send_request(OP_REMOVE, 7'd1);
        send_request(OP_READ, 7'd0);
        send_request(OP_UNUSED, 7'd1);
        send_request(OP_INSERT, 7'd127);
    endtask

    task automatic test_basic_operations();
        repeat (4) send_request(OP_INSERT, any_position());
        send_request(OP_READ, 7'd1);
        send_request(OP_READ, 7'd5);
        send_request(OP_REMOVE, 7'd3);
        send_request(OP_READ, 7'd3);
        send_request(OP_INSERT, 7'd0);
        send_request(OP_REMOVE, 7'd1);
        send_request(OP_INSERT, 7'd64);
        send_request(OP_REMOVE, POS_W'(list_count));
        send_request(OP_READ, 7'd127);
        send_request(OP_REMOVE, 7'd0);
        send_request(OP_UNUSED, 7'd2);
    endtask

    task automatic test_full_list();
        while (list_count < LIST_DEPTH) send_request(OP_INSERT, any_position());
        send_request(OP_INSERT, 7'd0);
        send_request(OP_INSERT, 7'd127);
        send_request(OP_READ, 7'd64);
        send_request(OP_REMOVE, 7'd64);
        send_request(OP_READ, 7'd65);
        send_request(OP_INSERT, 7'd1);
        send_request(OP_REMOVE, 7'd1);
        send_request(OP_INSERT, 7'd1);
    endtask

    task automatic test_output_hold_off();
        wait_until_drained();
        hold_off_req = 1'b1;
        while (!hold_active) @(negedge i_clk);
        sender_burst_left = 24;
        repeat (24) send_random_request(50);
        wait_until_drained();
    endtask

    task automatic test_random_traffic();
        int insert_pct;
        int phase_len;
        int phase;
        int sent_here;
        sent_here = 0;
        phase     = 0;
        while (sent_here < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: insert_pct = 15;
                1: insert_pct = 45;
                2: insert_pct = 60;
                default: insert_pct = 90;
            endcase
            phase_len = $urandom_range(40, 160);
            if (phase_len > RANDOM_ITEMS - sent_here) begin
                phase_len = RANDOM_ITEMS - sent_here;
            end
            repeat (phase_len) send_random_request(insert_pct);
            sent_here += phase_len;
            phase++;
            if (phase % 3 == 0) begin
                wait_until_drained();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_INSERT;
        i_position  <= '0;
        list_count  = 0;
        for (int k = 0; k < LIST_DEPTH; k++) list_labels[k] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_basic_operations();
        test_full_list();
        test_output_hold_off();
        test_random_traffic();
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results, peak fill %0d of %0d labels.",
                 items_sent, replies_checked, peak_fill, LIST_DEPTH);
        $display("Inserts into a full list: %0d, rejected positions or codes: %0d.",
                 full_inserts, rejected_reads);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
